### src/go_to_goal_velocity_controller_macros.svh
// ----------------------------------------------------------------------------
// Go-to-goal velocity controller assertion macros
// Shared concurrent assertion forms on the aclk/aresetn domain.
// ----------------------------------------------------------------------------
`ifndef GO_TO_GOAL_VELOCITY_CONTROLLER_MACROS_SVH
`define GO_TO_GOAL_VELOCITY_CONTROLLER_MACROS_SVH

// Same-cycle implication.
`define GTG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GTG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/gtg_pkg.sv
// ----------------------------------------------------------------------------
// Go-to-goal velocity controller package
// Widths, fixed-point constants, sequencer states and the arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package gtg_pkg;

    localparam int CORDIC_STEPS = 16;

    localparam int POS_W   = 24;
    localparam int QUAT_W  = 16;
    localparam int GAIN_W  = 16;
    localparam int SPD_W   = 23;
    localparam int TURN_W  = 18;
    localparam int ANG_W   = 16;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 3;
    localparam int MUL_W   = 25;
    localparam int PROD_W  = 50;
    localparam int ACC_W   = 51;
    localparam int CRD_W   = 36;
    localparam int Z_W     = 20;
    localparam int SQ_W    = 50;
    localparam int DIST_W  = 25;
    localparam int CNT_W   = 6;
    localparam int SQRT_TOP = 24;

    localparam logic [IDX_W-1:0] REG_TARGET_X  = 3'd0;
    localparam logic [IDX_W-1:0] REG_TARGET_Y  = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN      = 3'd2;
    localparam logic [IDX_W-1:0] REG_MAX_SPEED = 3'd3;
    localparam logic [IDX_W-1:0] REG_TOLERANCE = 3'd4;

    localparam logic OP_POSE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic signed [GAIN_W-1:0] GAIN_RESET  = 16'sd2048;
    localparam logic [SPD_W-1:0]         SPEED_RESET = 23'd410;
    localparam logic [SPD_W-1:0]         TOL_RESET   = 23'd205;

    localparam logic signed [Z_W-1:0]    HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [ACC_W-1:0]  ONE_Q28     = 51'sd268435456;
    localparam logic signed [ANG_W:0]    PI_Q12      = 17'sd12868;
    localparam logic signed [ANG_W:0]    TWO_PI_Q12  = 17'sd25736;
    localparam logic signed [ACC_W-1:0]  TURN_MAX    = 51'sd131071;
    localparam logic signed [ACC_W-1:0]  TURN_MIN    = -51'sd131072;
    localparam logic signed [ACC_W-1:0]  ROUND_Q12   = 51'sd2048;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PMUL,
        ST_PFORM,
        ST_TMUL,
        ST_SQRT,
        ST_SCHK,
        ST_CINIT,
        ST_CITER,
        ST_CDONE,
        ST_WRAP,
        ST_GMUL,
        ST_TURN,
        ST_OUT
    } state_t;

    function automatic logic signed [Z_W-1:0] atan_q16(input logic [4:0] idx);
        logic signed [Z_W-1:0] r;
        case (idx)
            5'd0:    r = 20'sd51472;
            5'd1:    r = 20'sd30386;
            5'd2:    r = 20'sd16055;
            5'd3:    r = 20'sd8150;
            5'd4:    r = 20'sd4091;
            5'd5:    r = 20'sd2047;
            5'd6:    r = 20'sd1024;
            5'd7:    r = 20'sd512;
            5'd8:    r = 20'sd256;
            5'd9:    r = 20'sd128;
            5'd10:   r = 20'sd64;
            5'd11:   r = 20'sd32;
            5'd12:   r = 20'sd16;
            5'd13:   r = 20'sd8;
            5'd14:   r = 20'sd4;
            5'd15:   r = 20'sd2;
            5'd16:   r = 20'sd1;
            default: r = 20'sd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### src/go_to_goal_velocity_controller.sv
// ----------------------------------------------------------------------------
// Go-to-goal velocity controller
// Stores pose and yaw, and answers control ticks with linear speed and
// turn rate from a proportional heading law, using one shared multiplier,
// one CORDIC vectoring stage and one square root stage under a sequencer.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                Payload
// s_        in         s_valid / s_ready        opcode, pose_x/y, quat_x/y/z/w
// m_        out        m_valid / m_ready        linear_speed, turn_rate, at_target
// cfg_      in         cfg_wr_en                cfg_index, cfg_wr_data
//
// A pose transaction runs four multiplier passes, the operand setup and
// CORDIC_STEPS iterations of the CORDIC stage. A tick runs two multiplier
// passes, 25 square root steps, the CORDIC iterations and the wrap, gain and
// saturation steps; a tick at the goal skips the CORDIC. A tick before any pose
// is dropped. The block accepts one transaction at a time. A finished result
// waits in the output register while the next transaction is taken, and a tick
// holds in its last state while the previous result still waits. Reset is
// synchronous and active low.
// ----------------------------------------------------------------------------
`default_nettype none

module go_to_goal_velocity_controller (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  wire                                   s_opcode,
    input  wire signed [gtg_pkg::POS_W-1:0]       s_pose_x,
    input  wire signed [gtg_pkg::POS_W-1:0]       s_pose_y,
    input  wire signed [gtg_pkg::QUAT_W-1:0]      s_quat_x,
    input  wire signed [gtg_pkg::QUAT_W-1:0]      s_quat_y,
    input  wire signed [gtg_pkg::QUAT_W-1:0]      s_quat_z,
    input  wire signed [gtg_pkg::QUAT_W-1:0]      s_quat_w,
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output logic [gtg_pkg::SPD_W-1:0]             m_linear_speed,
    output logic signed [gtg_pkg::TURN_W-1:0]     m_turn_rate,
    output logic                                  m_at_target,
    input  wire                                   cfg_wr_en,
    input  wire [gtg_pkg::IDX_W-1:0]              cfg_index,
    input  wire [gtg_pkg::CFG_W-1:0]              cfg_wr_data
);

`include "go_to_goal_velocity_controller_macros.svh"

    gtg_pkg::state_t state_reg, state_next;

    logic [gtg_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic op_reg, op_next;

    logic signed [gtg_pkg::POS_W-1:0]  tx_reg, ty_reg;
    logic signed [gtg_pkg::GAIN_W-1:0] gain_reg;
    logic [gtg_pkg::SPD_W-1:0]         max_reg, tol_reg;

    logic signed [gtg_pkg::POS_W-1:0]  held_x_reg, held_x_next, held_y_reg, held_y_next;
    logic signed [gtg_pkg::ANG_W-1:0]  held_yaw_reg, held_yaw_next;
    logic pose_seen_reg, pose_seen_next;

    logic signed [gtg_pkg::QUAT_W-1:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic signed [gtg_pkg::QUAT_W-1:0] qx_next, qy_next, qz_next, qw_next;
    logic signed [gtg_pkg::MUL_W-1:0]  dx_reg, dx_next, dy_reg, dy_next;

    logic signed [gtg_pkg::ACC_W-1:0]  acc_reg, acc_next, ssum_reg, ssum_next;
    logic signed [gtg_pkg::CRD_W-1:0]  cx_reg, cx_next, cy_reg, cy_next;
    logic signed [gtg_pkg::Z_W-1:0]    cz_reg, cz_next;
    logic signed [gtg_pkg::ANG_W-1:0]  ang_reg, ang_next;
    logic signed [gtg_pkg::ANG_W:0]    err_reg, err_next;
    logic [gtg_pkg::SQ_W-1:0]          rem_reg, rem_next, root_reg, root_next;

    logic [gtg_pkg::SPD_W-1:0]         lin_res_reg, lin_res_next;
    logic signed [gtg_pkg::TURN_W-1:0] turn_res_reg, turn_res_next;
    logic                              tgt_res_reg, tgt_res_next;

    logic                              m_valid_reg, m_valid_next;
    logic [gtg_pkg::SPD_W-1:0]         m_lin_reg, m_lin_next;
    logic signed [gtg_pkg::TURN_W-1:0] m_turn_reg, m_turn_next;
    logic                              m_tgt_reg, m_tgt_next;

    logic signed [gtg_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic signed [gtg_pkg::PROD_W-1:0] product;

    logic                              s_fire;
    logic                              cordic_zero;
    logic                              cordic_last;
    logic                              out_free;
    logic [gtg_pkg::DIST_W-1:0]        dist_q;
    logic                              near_goal;
    logic [gtg_pkg::SQ_W-1:0]          sq_bit, sq_trial;
    logic signed [gtg_pkg::CRD_W-1:0]  cx_sh, cy_sh;
    logic signed [gtg_pkg::Z_W-1:0]    atan_val;
    logic signed [gtg_pkg::Z_W-1:0]    z_round;
    logic signed [gtg_pkg::ANG_W:0]    diff;
    logic signed [gtg_pkg::ACC_W-1:0]  turn_full;

    assign s_ready        = (state_reg == gtg_pkg::ST_IDLE);
    assign s_fire         = s_valid && s_ready;
    assign m_valid        = m_valid_reg;
    assign m_linear_speed = m_lin_reg;
    assign m_turn_rate    = m_turn_reg;
    assign m_at_target    = m_tgt_reg;

    assign cordic_zero = (cx_reg == '0) && (cy_reg == '0);
    assign cordic_last = (cnt_reg == gtg_pkg::CNT_W'(gtg_pkg::CORDIC_STEPS - 1));
    assign out_free    = !m_valid_reg || m_ready;
    assign dist_q      = root_reg[gtg_pkg::DIST_W-1:0];
    assign near_goal   = dist_q < {2'b00, tol_reg};

    assign product  = mul_a * mul_b;
    assign sq_bit   = gtg_pkg::SQ_W'(1) << {cnt_reg[4:0], 1'b0};
    assign sq_trial = root_reg + sq_bit;
    assign cx_sh    = cx_reg >>> cnt_reg[4:0];
    assign cy_sh    = cy_reg >>> cnt_reg[4:0];
    assign atan_val = gtg_pkg::atan_q16(cnt_reg[4:0]);
    assign z_round  = (cz_reg + 20'sd8) >>> 4;
    assign diff     = {ang_reg[gtg_pkg::ANG_W-1], ang_reg}
                    - {held_yaw_reg[gtg_pkg::ANG_W-1], held_yaw_reg};
    assign turn_full = (acc_reg + gtg_pkg::ROUND_Q12) >>> 12;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            gtg_pkg::ST_PMUL: begin
                case (cnt_reg[1:0])
                    2'd0: begin
                        mul_a = gtg_pkg::MUL_W'(qw_reg);
                        mul_b = gtg_pkg::MUL_W'(qz_reg);
                    end
                    2'd1: begin
                        mul_a = gtg_pkg::MUL_W'(qx_reg);
                        mul_b = gtg_pkg::MUL_W'(qy_reg);
                    end
                    2'd2: begin
                        mul_a = gtg_pkg::MUL_W'(qy_reg);
                        mul_b = gtg_pkg::MUL_W'(qy_reg);
                    end
                    default: begin
                        mul_a = gtg_pkg::MUL_W'(qz_reg);
                        mul_b = gtg_pkg::MUL_W'(qz_reg);
                    end
                endcase
            end
            gtg_pkg::ST_TMUL: begin
                mul_a = cnt_reg[0] ? dy_reg : dx_reg;
                mul_b = cnt_reg[0] ? dy_reg : dx_reg;
            end
            gtg_pkg::ST_GMUL: begin
                mul_a = gtg_pkg::MUL_W'(gain_reg);
                mul_b = gtg_pkg::MUL_W'(err_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gtg_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (s_opcode == gtg_pkg::OP_POSE) begin
                        state_next = gtg_pkg::ST_PMUL;
                    end else if (pose_seen_reg) begin
                        state_next = gtg_pkg::ST_TMUL;
                    end
                end
            end
            gtg_pkg::ST_PMUL: begin
                if (cnt_reg[1:0] == 2'd3) begin
                    state_next = gtg_pkg::ST_PFORM;
                end
            end
            gtg_pkg::ST_PFORM: state_next = gtg_pkg::ST_CINIT;
            gtg_pkg::ST_TMUL: begin
                if (cnt_reg[0]) begin
                    state_next = gtg_pkg::ST_SQRT;
                end
            end
            gtg_pkg::ST_SQRT: begin
                if (cnt_reg == '0) begin
                    state_next = gtg_pkg::ST_SCHK;
                end
            end
            gtg_pkg::ST_SCHK: state_next = near_goal ? gtg_pkg::ST_OUT : gtg_pkg::ST_CINIT;
            gtg_pkg::ST_CINIT: state_next = cordic_zero ? gtg_pkg::ST_CDONE : gtg_pkg::ST_CITER;
            gtg_pkg::ST_CITER: begin
                if (cordic_last) begin
                    state_next = gtg_pkg::ST_CDONE;
                end
            end
            gtg_pkg::ST_CDONE: begin
                state_next = (op_reg == gtg_pkg::OP_POSE) ? gtg_pkg::ST_IDLE : gtg_pkg::ST_WRAP;
            end
            gtg_pkg::ST_WRAP: state_next = gtg_pkg::ST_GMUL;
            gtg_pkg::ST_GMUL: state_next = gtg_pkg::ST_TURN;
            gtg_pkg::ST_TURN: state_next = gtg_pkg::ST_OUT;
            gtg_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = gtg_pkg::ST_IDLE;
                end
            end
            default: state_next = gtg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        held_x_next    = held_x_reg;
        held_y_next    = held_y_reg;
        held_yaw_next  = held_yaw_reg;
        pose_seen_next = pose_seen_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        qz_next        = qz_reg;
        qw_next        = qw_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        acc_next       = acc_reg;
        ssum_next      = ssum_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        ang_next       = ang_reg;
        err_next       = err_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        lin_res_next   = lin_res_reg;
        turn_res_next  = turn_res_reg;
        tgt_res_next   = tgt_res_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_lin_next     = m_lin_reg;
        m_turn_next    = m_turn_reg;
        m_tgt_next     = m_tgt_reg;

        case (state_reg)
            gtg_pkg::ST_IDLE: begin
                cnt_next = '0;
                if (s_fire) begin
                    op_next = s_opcode;
                    if (s_opcode == gtg_pkg::OP_POSE) begin
                        held_x_next = s_pose_x;
                        held_y_next = s_pose_y;
                        qx_next     = s_quat_x;
                        qy_next     = s_quat_y;
                        qz_next     = s_quat_z;
                        qw_next     = s_quat_w;
                    end else begin
                        dx_next = gtg_pkg::MUL_W'(tx_reg) - gtg_pkg::MUL_W'(held_x_reg);
                        dy_next = gtg_pkg::MUL_W'(ty_reg) - gtg_pkg::MUL_W'(held_y_reg);
                    end
                end
            end
            gtg_pkg::ST_PMUL: begin
                cnt_next = cnt_reg + 1'b1;
                case (cnt_reg[1:0])
                    2'd0:    acc_next = gtg_pkg::ACC_W'(product);
                    2'd1:    ssum_next = acc_reg + gtg_pkg::ACC_W'(product);
                    2'd2:    acc_next = gtg_pkg::ACC_W'(product);
                    default: acc_next = acc_reg + gtg_pkg::ACC_W'(product);
                endcase
            end
            gtg_pkg::ST_PFORM: begin
                cy_next = gtg_pkg::CRD_W'(ssum_reg <<< 1);
                cx_next = gtg_pkg::CRD_W'(gtg_pkg::ONE_Q28 - (acc_reg <<< 1));
            end
            gtg_pkg::ST_TMUL: begin
                if (cnt_reg[0]) begin
                    rem_next  = gtg_pkg::SQ_W'(acc_reg + gtg_pkg::ACC_W'(product));
                    root_next = '0;
                    cnt_next  = gtg_pkg::CNT_W'(gtg_pkg::SQRT_TOP);
                end else begin
                    acc_next = gtg_pkg::ACC_W'(product);
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            gtg_pkg::ST_SQRT: begin
                if (rem_reg >= sq_trial) begin
                    rem_next  = rem_reg - sq_trial;
                    root_next = (root_reg >> 1) + sq_bit;
                end else begin
                    root_next = root_reg >> 1;
                end
                cnt_next = cnt_reg - 1'b1;
            end
            gtg_pkg::ST_SCHK: begin
                cx_next = gtg_pkg::CRD_W'(dx_reg);
                cy_next = gtg_pkg::CRD_W'(dy_reg);
                if (near_goal) begin
                    lin_res_next  = '0;
                    turn_res_next = '0;
                    tgt_res_next  = 1'b1;
                end
            end
            gtg_pkg::ST_CINIT: begin
                cnt_next = '0;
                cz_next  = '0;
                if (cx_reg < 0) begin
                    if (cy_reg >= 0) begin
                        cx_next = cy_reg;
                        cy_next = -cx_reg;
                        cz_next = gtg_pkg::HALF_PI_Q16;
                    end else begin
                        cx_next = -cy_reg;
                        cy_next = cx_reg;
                        cz_next = -gtg_pkg::HALF_PI_Q16;
                    end
                end
            end
            gtg_pkg::ST_CITER: begin
                cnt_next = cnt_reg + 1'b1;
                if (cy_reg > 0) begin
                    cx_next = cx_reg + cy_sh;
                    cy_next = cy_reg - cx_sh;
                    cz_next = cz_reg + atan_val;
                end else begin
                    cx_next = cx_reg - cy_sh;
                    cy_next = cy_reg + cx_sh;
                    cz_next = cz_reg - atan_val;
                end
            end
            gtg_pkg::ST_CDONE: begin
                if (op_reg == gtg_pkg::OP_POSE) begin
                    held_yaw_next  = z_round[gtg_pkg::ANG_W-1:0];
                    pose_seen_next = 1'b1;
                end else begin
                    ang_next = z_round[gtg_pkg::ANG_W-1:0];
                end
            end
            gtg_pkg::ST_WRAP: begin
                if (diff > gtg_pkg::PI_Q12) begin
                    err_next = diff - gtg_pkg::TWO_PI_Q12;
                end else if (diff < -gtg_pkg::PI_Q12) begin
                    err_next = diff + gtg_pkg::TWO_PI_Q12;
                end else begin
                    err_next = diff;
                end
            end
            gtg_pkg::ST_GMUL: begin
                acc_next = gtg_pkg::ACC_W'(product);
            end
            gtg_pkg::ST_TURN: begin
                tgt_res_next = 1'b0;
                lin_res_next = (dist_q < {2'b00, max_reg}) ? dist_q[gtg_pkg::SPD_W-1:0]
                                                           : max_reg;
                if (turn_full > gtg_pkg::TURN_MAX) begin
                    turn_res_next = gtg_pkg::TURN_W'(gtg_pkg::TURN_MAX);
                end else if (turn_full < gtg_pkg::TURN_MIN) begin
                    turn_res_next = gtg_pkg::TURN_W'(gtg_pkg::TURN_MIN);
                end else begin
                    turn_res_next = turn_full[gtg_pkg::TURN_W-1:0];
                end
            end
            gtg_pkg::ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_lin_next   = lin_res_reg;
                    m_turn_next  = turn_res_reg;
                    m_tgt_next   = tgt_res_reg;
                end
            end
            default: begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= gtg_pkg::ST_IDLE;
            cnt_reg       <= '0;
            held_x_reg    <= '0;
            held_y_reg    <= '0;
            held_yaw_reg  <= '0;
            pose_seen_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            held_x_reg    <= held_x_next;
            held_y_reg    <= held_y_next;
            held_yaw_reg  <= held_yaw_next;
            pose_seen_reg <= pose_seen_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_reg   <= '0;
            ty_reg   <= '0;
            gain_reg <= gtg_pkg::GAIN_RESET;
            max_reg  <= gtg_pkg::SPEED_RESET;
            tol_reg  <= gtg_pkg::TOL_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                gtg_pkg::REG_TARGET_X:  tx_reg   <= cfg_wr_data;
                gtg_pkg::REG_TARGET_Y:  ty_reg   <= cfg_wr_data;
                gtg_pkg::REG_GAIN:      gain_reg <= cfg_wr_data[gtg_pkg::GAIN_W-1:0];
                gtg_pkg::REG_MAX_SPEED: max_reg  <= cfg_wr_data[gtg_pkg::SPD_W-1:0];
                gtg_pkg::REG_TOLERANCE: tol_reg  <= cfg_wr_data[gtg_pkg::SPD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        qx_reg       <= qx_next;
        qy_reg       <= qy_next;
        qz_reg       <= qz_next;
        qw_reg       <= qw_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        acc_reg      <= acc_next;
        ssum_reg     <= ssum_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        cz_reg       <= cz_next;
        ang_reg      <= ang_next;
        err_reg      <= err_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        lin_res_reg  <= lin_res_next;
        turn_res_reg <= turn_res_next;
        tgt_res_reg  <= tgt_res_next;
        m_lin_reg    <= m_lin_next;
        m_turn_reg   <= m_turn_next;
        m_tgt_reg    <= m_tgt_next;
    end

    // A result at the goal carries no motion command.
    `GTG_ASSERT_SAME(a_goal_still, m_valid && m_at_target, (m_linear_speed == '0) && (m_turn_rate == '0), "motion commanded at goal")
    // Away from the goal the speed never exceeds the configured cap.
    `GTG_ASSERT_SAME(a_speed_cap, m_valid && !m_at_target, m_linear_speed <= max_reg, "speed above cap")
    // The CORDIC counter stays inside the table.
    `GTG_ASSERT_SAME(a_cordic_cnt, state_reg == gtg_pkg::ST_CITER, cnt_reg < gtg_pkg::CNT_W'(gtg_pkg::CORDIC_STEPS), "CORDIC counter overrun")
    // A tick is only worked on after a pose has been stored.
    `GTG_ASSERT_SAME(a_tick_pose, state_reg == gtg_pkg::ST_TMUL, pose_seen_reg, "tick without pose")
    // A finished pose transaction leaves a pose marked as seen.
    `GTG_ASSERT_NEXT(a_pose_mark, state_reg == gtg_pkg::ST_CDONE && op_reg == gtg_pkg::OP_POSE, pose_seen_reg && (state_reg == gtg_pkg::ST_IDLE), "pose not recorded")

endmodule

`default_nettype wire

### sim/gtg_checker.sv
// ----------------------------------------------------------------------------
// Go-to-goal velocity controller checker
// Watches the input, result and register ports, predicts each result from its
// own model of the pose store, CORDIC heading and square root distance, and
// compares every result transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module gtg_checker (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_valid,
    input  wire                                s_ready,
    input  wire                                s_opcode,
    input  wire signed [gtg_pkg::POS_W-1:0]    s_pose_x,
    input  wire signed [gtg_pkg::POS_W-1:0]    s_pose_y,
    input  wire signed [gtg_pkg::QUAT_W-1:0]   s_quat_x,
    input  wire signed [gtg_pkg::QUAT_W-1:0]   s_quat_y,
    input  wire signed [gtg_pkg::QUAT_W-1:0]   s_quat_z,
    input  wire signed [gtg_pkg::QUAT_W-1:0]   s_quat_w,
    input  wire                                m_valid,
    input  wire                                m_ready,
    input  wire [gtg_pkg::SPD_W-1:0]           m_linear_speed,
    input  wire signed [gtg_pkg::TURN_W-1:0]   m_turn_rate,
    input  wire                                m_at_target,
    input  wire                                cfg_wr_en,
    input  wire [gtg_pkg::IDX_W-1:0]           cfg_index,
    input  wire [gtg_pkg::CFG_W-1:0]           cfg_wr_data,
    output int                                 fail_count,
    output int                                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [gtg_pkg::SPD_W-1:0]         speed;
        logic signed [gtg_pkg::TURN_W-1:0] turn;
        logic                              arrived;
    } command_t;

    command_t commands_due[$];

    longint goal_x, goal_y, gain, speed_cap, tolerance;
    longint pos_x, pos_y, yaw;
    bit     have_pose;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint heading_q12(longint y, longint x);
        longint z, nx, ny, xs, ys;
        const longint atan_tab[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
                                       512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                nx = y; ny = -x; z = 102944;
            end else begin
                nx = -y; ny = x; z = -102944;
            end
            x = nx; y = ny;
        end
        for (int i = 0; i < gtg_pkg::CORDIC_STEPS; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y > 0) begin
                x += ys; y -= xs; z += (i < 17) ? atan_tab[i] : 0;
            end else begin
                x -= ys; y += xs; z -= (i < 17) ? atan_tab[i] : 0;
            end
        end
        return floor_shift(z + 8, 4);
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b; res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    task automatic predict_command();
        longint dx, dy, range_q, err, turn;
        command_t c;
        dx = goal_x - pos_x;
        dy = goal_y - pos_y;
        range_q = root_floor(dx * dx + dy * dy);
        if (range_q < tolerance) begin
            c = '{speed: '0, turn: '0, arrived: 1'b1};
        end else begin
            err = heading_q12(dy, dx) - yaw;
            while (err > 12868) err -= 25736;
            while (err < -12868) err += 25736;
            turn = floor_shift(gain * err + 2048, 12);
            if (turn > 131071) turn = 131071;
            if (turn < -131072) turn = -131072;
            c.speed = gtg_pkg::SPD_W'((range_q < speed_cap) ? range_q : speed_cap);
            c.turn = gtg_pkg::TURN_W'(turn);
            c.arrived = 1'b0;
        end
        commands_due.push_back(c);
    endtask

    always @(posedge aclk) begin
        longint qx, qy, qz, qw;
        command_t want;
        if (!aresetn) begin
            goal_x = 0; goal_y = 0; gain = 2048; speed_cap = 410; tolerance = 205;
            pos_x = 0; pos_y = 0; yaw = 0; have_pose = 0;
            commands_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    gtg_pkg::REG_TARGET_X:
                        goal_x = longint'($signed(cfg_wr_data[gtg_pkg::POS_W-1:0]));
                    gtg_pkg::REG_TARGET_Y:
                        goal_y = longint'($signed(cfg_wr_data[gtg_pkg::POS_W-1:0]));
                    gtg_pkg::REG_GAIN:
                        gain = longint'($signed(cfg_wr_data[gtg_pkg::GAIN_W-1:0]));
                    gtg_pkg::REG_MAX_SPEED:
                        speed_cap = longint'(cfg_wr_data[gtg_pkg::SPD_W-1:0]);
                    gtg_pkg::REG_TOLERANCE:
                        tolerance = longint'(cfg_wr_data[gtg_pkg::SPD_W-1:0]);
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_opcode == gtg_pkg::OP_POSE) begin
                    qx = s_quat_x; qy = s_quat_y; qz = s_quat_z; qw = s_quat_w;
                    pos_x = s_pose_x;
                    pos_y = s_pose_y;
                    yaw = heading_q12(2 * (qw * qz + qx * qy),
                                      (64'sd1 << 28) - 2 * (qy * qy + qz * qz));
                    have_pose = 1;
                end else if (have_pose) begin
                    predict_command();
                end
            end
            if (m_valid && m_ready) begin
                if (commands_due.size() == 0) begin
                    $error("Result transaction with no prediction waiting");
                    fail_count++;
                end else begin
                    want = commands_due.pop_front();
                    if (m_linear_speed !== want.speed) begin
                        $error("linear_speed: expected %0d, got %0d", want.speed,
                               m_linear_speed);
                        fail_count++;
                    end
                    if (m_turn_rate !== want.turn) begin
                        $error("turn_rate: expected %0d, got %0d", want.turn, m_turn_rate);
                        fail_count++;
                    end
                    if (m_at_target !== want.arrived) begin
                        $error("at_target: expected %0d, got %0d", want.arrived,
                               m_at_target);
                        fail_count++;
                    end
                end
            end
        end
        pending = commands_due.size();
    end

    initial begin
        fail_count = 0;
        pending = 0;
    end

endmodule

`default_nettype wire

### sim/tb_go_to_goal_velocity_controller.sv
// ----------------------------------------------------------------------------
// Go-to-goal velocity controller testbench
// Drives directed and random pose and tick transactions through several goal,
// gain, speed cap and tolerance settings with random gaps on both channels,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_go_to_goal_velocity_controller;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 1500000;
    localparam logic [gtg_pkg::IDX_W-1:0] REG_SPARE = 3'd6;

    logic aclk = 0, aresetn = 0;
    logic s_valid = 0, s_opcode = 0;
    logic signed [gtg_pkg::POS_W-1:0] s_pose_x = '0, s_pose_y = '0;
    logic signed [gtg_pkg::QUAT_W-1:0] s_quat_x = '0, s_quat_y = '0, s_quat_z = '0,
                                       s_quat_w = '0;
    logic m_ready = 0, cfg_wr_en = 0;
    logic [gtg_pkg::IDX_W-1:0] cfg_index = '0;
    logic [gtg_pkg::CFG_W-1:0] cfg_wr_data = '0;
    wire s_ready, m_valid, m_at_target;
    wire [gtg_pkg::SPD_W-1:0] m_linear_speed;
    wire signed [gtg_pkg::TURN_W-1:0] m_turn_rate;
    int fail_count, pending;
    int cycle_count = 0;
    bit quiet_phase = 0;

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    go_to_goal_velocity_controller DUT (.*);

    gtg_checker checker_i (.*);

    function automatic int gap_cycles();
        if (quiet_phase) return 0;
        if ($urandom_range(9) < 6) return 0;
        if ($urandom_range(9) < 8) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side stalls at random.
    initial begin
        int g;
        forever begin
            @(posedge aclk);
            g = gap_cycles();
            if (g == 0) begin
                m_ready <= 1;
            end else begin
                m_ready <= 0;
                repeat (g - 1) @(posedge aclk);
            end
        end
    end

    function automatic logic signed [gtg_pkg::QUAT_W-1:0] rand_quat();
        case ($urandom_range(5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            default: return $signed(16'($urandom_range(32768))) - 16'sd16384;
        endcase
    endfunction

    function automatic logic signed [gtg_pkg::POS_W-1:0] rand_pos(
        logic signed [gtg_pkg::POS_W-1:0] near);
        case ($urandom_range(7))
            0: return $signed(24'($urandom()));
            1: return near + $signed(24'($urandom_range(600))) - 24'sd300;
            default: return near + $signed(24'($urandom_range(65536))) - 24'sd32768;
        endcase
    endfunction

    task automatic send(logic op, logic signed [gtg_pkg::POS_W-1:0] px,
                        logic signed [gtg_pkg::POS_W-1:0] py,
                        logic signed [gtg_pkg::QUAT_W-1:0] qx,
                        logic signed [gtg_pkg::QUAT_W-1:0] qy,
                        logic signed [gtg_pkg::QUAT_W-1:0] qz,
                        logic signed [gtg_pkg::QUAT_W-1:0] qw);
        repeat (gap_cycles()) @(posedge aclk);
        s_valid <= 1;
        s_opcode <= op;
        s_pose_x <= px; s_pose_y <= py;
        s_quat_x <= qx; s_quat_y <= qy; s_quat_z <= qz; s_quat_w <= qw;
        do @(posedge aclk); while (!s_ready);
        s_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic write_reg(logic [gtg_pkg::IDX_W-1:0] idx,
                             logic [gtg_pkg::CFG_W-1:0] val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (pending != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic random_pose(logic signed [gtg_pkg::POS_W-1:0] near);
        send(gtg_pkg::OP_POSE, rand_pos(near), rand_pos(near),
             rand_quat(), rand_quat(), rand_quat(), rand_quat());
    endtask

    initial begin
        logic signed [gtg_pkg::POS_W-1:0] goal;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: ticks before pose, field extremes, reset settings.
        send(gtg_pkg::OP_TICK, '0, '0, '0, '0, '0, '0);
        send(gtg_pkg::OP_TICK, 24'sh7FFFFF, 24'sh800000, '0, '0, '0, '0);
        send(gtg_pkg::OP_POSE, '0, '0, '0, '0, '0, 16'sd16384);
        send(gtg_pkg::OP_TICK, '0, '0, '0, '0, '0, '0);
        send(gtg_pkg::OP_POSE, 24'sd100, '0, '0, '0, '0, '0);
        send(gtg_pkg::OP_TICK, '0, '0, '0, '0, '0, '0);
        send(gtg_pkg::OP_POSE, 24'sh7FFFFF, 24'sh7FFFFF, 16'sd16384, 16'sd16384,
             16'sd16384, 16'sd16384);
        send(gtg_pkg::OP_TICK, '0, '0, '0, '0, '0, '0);
        send(gtg_pkg::OP_POSE, 24'sh800000, 24'sh800000, -16'sd16384, -16'sd16384,
             -16'sd16384, -16'sd16384);
        send(gtg_pkg::OP_TICK, '1, '1, '1, '1, '1, '1);
        send(gtg_pkg::OP_POSE, 24'sh7FFFFF, 24'sh800000, 16'sd0, 16'sd0, 16'sd16384,
             16'sd0);
        send(gtg_pkg::OP_TICK, '0, '0, '0, '0, '0, '0);
        send(gtg_pkg::OP_POSE, -24'sd4096, 24'sd0, 16'sd0, 16'sd0, 16'sd11585,
             16'sd11585);
        send(gtg_pkg::OP_TICK, '0, '0, '0, '0, '0, '0);
        drain();

        write_reg(gtg_pkg::REG_TARGET_X, 24'h800000);
        write_reg(gtg_pkg::REG_TARGET_Y, 24'h7FFFFF);
        write_reg(gtg_pkg::REG_GAIN, 24'h007FFF);
        write_reg(gtg_pkg::REG_MAX_SPEED, 24'h7FFFFF);
        write_reg(gtg_pkg::REG_TOLERANCE, 24'h000000);
        write_reg(REG_SPARE, 24'hFFFFFF);
        send(gtg_pkg::OP_POSE, 24'sh7FFFFF, 24'sh800000, '0, '0, 16'sd16384, '0);
        send(gtg_pkg::OP_TICK, '0, '0, '0, '0, '0, '0);
        send(gtg_pkg::OP_POSE, 24'sh800000, 24'sh7FFFFF, '0, '0, '0, 16'sd16384);
        send(gtg_pkg::OP_TICK, '0, '0, '0, '0, '0, '0);
        drain();
        write_reg(gtg_pkg::REG_GAIN, 24'h008000);
        write_reg(gtg_pkg::REG_TOLERANCE, 24'h7FFFFF);
        send(gtg_pkg::OP_TICK, '0, '0, '0, '0, '0, '0);
        drain();

        for (int phase = 0; phase < 9; phase++) begin
            goal = $signed(24'($urandom()));
            write_reg(gtg_pkg::REG_TARGET_X, 24'(goal));
            write_reg(gtg_pkg::REG_TARGET_Y, 24'(goal + $signed(24'($urandom_range(8192)))));
            write_reg(gtg_pkg::REG_GAIN, (phase == 0) ? 24'h8000 : (phase == 1) ? 24'h7FFF
                                         : 24'($urandom()));
            write_reg(gtg_pkg::REG_MAX_SPEED, (phase == 2) ? 24'h0
                                              : (phase == 3) ? 24'h7FFFFF
                                              : 24'($urandom_range(20000)));
            write_reg(gtg_pkg::REG_TOLERANCE, (phase == 4) ? 24'h7FFFFF
                                              : (phase == 5) ? 24'h0
                                              : 24'($urandom_range(3000)));
            quiet_phase = (phase == 6);
            for (int k = 0; k < 150; k++) begin
                if ($urandom_range(2) == 0) random_pose(goal);
                else send(gtg_pkg::OP_TICK, $signed(24'($urandom())),
                          $signed(24'($urandom())),
                          $signed(16'($urandom())), $signed(16'($urandom())),
                          $signed(16'($urandom())), $signed(16'($urandom())));
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
